@@ rtl/core/rcfd_pkg.sv @@
`default_nettype none

package rcfd_pkg;

    localparam int unsigned PAYLOAD_BYTES = 22;
    localparam int unsigned NUM_CH        = 16;
    localparam int unsigned CH_W          = 11;
    localparam int unsigned PAYLOAD_W     = PAYLOAD_BYTES * 8;

    localparam logic [4:0] LENGTH_POS    = 5'd1;
    localparam logic [4:0] TYPE_POS      = 5'd2;
    localparam logic [4:0] FIRST_PAYLOAD = 5'd3;
    localparam logic [4:0] LAST_PAYLOAD  = 5'd24;
    localparam logic [4:0] CRC_POS       = 5'd25;
    localparam logic [4:0] IDLE_POS      = 5'd26;

    localparam logic [7:0] EXPECTED_LEN = 8'd24;
    localparam logic [7:0] CRC_POLY     = 8'hD5;
    localparam logic [3:0] LAST_CH      = 4'd15;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_BAD_LENGTH,
        STATUS_BAD_CRC
    } status_t;

    // Completed frame handed from the parser to the emitter
    typedef struct packed {
        logic                 valid;
        status_t              status;
        logic [PAYLOAD_W-1:0] payload;
    } frame_evt_t;

    // CRC-8, MSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/rcfd_parser.sv @@
`default_nettype none

module rcfd_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          rx_byte,
    input  wire logic                frame_start,
    input  wire logic                busy,
    output rcfd_pkg::frame_evt_t     evt
);
    import rcfd_pkg::*;

    logic [4:0] pos_reg, pos_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] payload_reg [PAYLOAD_BYTES];
    logic       wr_en;
    logic [4:0] wr_idx;
    logic       accept;

    // Hold the CRC byte while the emitter still owns the previous frame
    assign s_tready = !(busy && (pos_reg == CRC_POS));
    assign accept   = s_tvalid && s_tready;
    assign wr_idx   = pos_reg - FIRST_PAYLOAD;

    always_comb
    begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        wr_en      = 1'b0;
        evt.valid  = 1'b0;
        evt.status = STATUS_OK;
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            evt.payload[i*8 +: 8] = payload_reg[i];
        end
        if (accept)
        begin
            if (frame_start)
            begin
                pos_next = LENGTH_POS;
                len_next = '0;
                crc_next = '0;
            end
            else if (pos_reg >= IDLE_POS)
            begin
                pos_next = IDLE_POS;
            end
            else if (pos_reg == CRC_POS)
            begin
                pos_next  = IDLE_POS;
                evt.valid = 1'b1;
                if (len_reg != EXPECTED_LEN)
                begin
                    evt.status = STATUS_BAD_LENGTH;
                end
                else if (crc_reg != rx_byte)
                begin
                    evt.status = STATUS_BAD_CRC;
                end
            end
            else
            begin
                pos_next = pos_reg + 5'd1;
                if (pos_reg == LENGTH_POS)
                begin
                    len_next = rx_byte;
                end
                else if (pos_reg == TYPE_POS)
                begin
                    crc_next = crc8_update(crc_reg, rx_byte);
                end
                else if (pos_reg >= FIRST_PAYLOAD && pos_reg <= LAST_PAYLOAD)
                begin
                    crc_next = crc8_update(crc_reg, rx_byte);
                    wr_en    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= IDLE_POS;
            len_reg <= '0;
            crc_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            payload_reg[wr_idx] <= rx_byte;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rcfd_emitter.sv @@
`default_nettype none

module rcfd_emitter (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  rcfd_pkg::frame_evt_t      evt,
    output logic                      busy,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output rcfd_pkg::status_t         status,
    output logic [3:0]                channel_index,
    output logic [rcfd_pkg::CH_W-1:0] channel_value,
    output logic                      last
);
    import rcfd_pkg::*;

    logic [PAYLOAD_W-1:0] snap_reg, snap_next;
    status_t              stat_reg, stat_next;
    logic [3:0]           ch_reg, ch_next;
    logic                 active_reg, active_next;

    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [3:0]           out_index_reg, out_index_next;
    logic [CH_W-1:0]      out_value_reg, out_value_next;
    logic                 out_last_reg, out_last_next;

    logic [CH_W-1:0]      ch_arr [NUM_CH];
    logic                 adv;
    logic                 is_last;

    for (genvar g = 0; g < NUM_CH; g++)
    begin : g_unpack
        assign ch_arr[g] = snap_reg[g*CH_W +: CH_W];
    end

    assign busy    = active_reg;
    assign adv     = active_reg && (!out_valid_reg || m_tready);
    assign is_last = (stat_reg != STATUS_OK) || (ch_reg == LAST_CH);

    always_comb
    begin
        snap_next       = snap_reg;
        stat_next       = stat_reg;
        ch_next         = ch_reg;
        active_next     = active_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        if (adv)
        begin
            out_valid_next  = 1'b1;
            out_status_next = stat_reg;
            out_index_next  = (stat_reg == STATUS_OK) ? ch_reg : 4'd0;
            out_value_next  = (stat_reg == STATUS_OK) ? ch_arr[ch_reg] : '0;
            out_last_next   = is_last;
            ch_next         = ch_reg + 4'd1;
            active_next     = !is_last;
        end
        if (evt.valid)
        begin
            snap_next   = evt.payload;
            stat_next   = evt.status;
            ch_next     = '0;
            active_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            ch_reg        <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            ch_reg        <= ch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg       <= snap_next;
        stat_reg       <= stat_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid      = out_valid_reg;
    assign status        = out_status_reg;
    assign channel_index = out_index_reg;
    assign channel_value = out_value_reg;
    assign last          = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/core/rc_channel_frame_decoder_top.sv @@
// The CRC byte transfer loads the frame snapshot; the first result then passes through the output register.
// Throughput: one byte per cycle; a good frame drains sixteen results, one per cycle
//   while m_tready is high, from a snapshot, so only the next frame's CRC byte waits.
// Reset: rst_n is asynchronous, active low; the parser goes idle until a frame start
//   and the result side empties. Payload bytes and the snapshot are not cleared.
`default_nettype none

module rc_channel_frame_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]  s_tuser,   // [0] frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [1:0] status, [5:2] channel_index,
                                        // [16:6] channel_value, [23:17] zero
    output logic             m_tlast    // last result of a frame
);
    import rcfd_pkg::*;

    frame_evt_t      evt;
    logic            busy;
    status_t         status;
    logic [3:0]      channel_index;
    logic [CH_W-1:0] channel_value;

    // Parser: byte position, length, running CRC and the payload bytes.
    // A CRC byte transfer closes the frame and raises a one-cycle event.
    rcfd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser[0]),
        .busy        (busy),
        .evt         (evt)
    );

    // Emitter: snapshot the frame, then advance one channel per result transfer
    // through the output register; an error frame gives a single result.
    rcfd_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .evt           (evt),
        .busy          (busy),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .status        (status),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last          (m_tlast)
    );

    assign m_tdata = {7'd0, channel_value, channel_index, status};

`ifndef NO_ASSERTIONS
    // A new frame never lands on a snapshot that is still draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid |-> !busy)
        else $error("frame event while emitter busy");

    // Error results always close the frame
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] != STATUS_OK)) |-> m_tlast)
        else $error("error result without last");

    // A good frame ends on the final channel
    a_ok_last_ch: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast && (m_tdata[1:0] == STATUS_OK)) |-> (m_tdata[5:2] == LAST_CH))
        else $error("good frame closed before last channel");
`endif

endmodule

`default_nettype wire

@@ bench/rc_channel_frame_decoder_chk.sv @@
`default_nettype none

module rc_channel_frame_decoder_chk (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]  s_tuser,   // [0] frame_start
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // [1:0] status, [5:2] channel_index,
                                        // [16:6] channel_value, [23:17] zero
    input  wire logic        m_tlast,
    output int               mismatches,
    output int               outstanding
);

    import rcfd_pkg::*;

    typedef struct packed {
        status_t             status;
        logic [3:0]          index;
        logic [CH_W-1:0]     value;
        logic                last;
    } chan_result_t;

    chan_result_t due_results[$];

    logic [4:0]  frame_pos;
    logic [7:0]  length_byte;
    logic [7:0]  crc_acc;
    logic [7:0]  payload_bytes [PAYLOAD_BYTES];
    int          errs = 0;

    // CRC-8 fed one bit at a time, MSB first
    function automatic logic [7:0] crc_shift(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        int         k;
        r = crc_in;
        for (k = 7; k >= 0; k--)
        begin
            fb = r[7] ^ data[k];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    task automatic queue_result(input status_t st, input logic [3:0] idx,
                                input logic [CH_W-1:0] val, input logic lst);
        chan_result_t r;
        r.status = st;
        r.index  = idx;
        r.value  = val;
        r.last   = lst;
        due_results.push_back(r);
    endtask

    task automatic flag(input string what, input int unsigned want, input int unsigned got);
        if (errs < 30)
        begin
            $display("%0t %s: expected %0d, actual %0d", $time, what, want, got);
        end
        errs++;
    endtask

    // Advance the frame parser by one byte
    task automatic parse_byte(input logic [7:0] b, input logic start);
        logic [PAYLOAD_W-1:0] flat;
        int                   i;
        if (start)
        begin
            frame_pos   = LENGTH_POS;
            length_byte = '0;
            crc_acc     = '0;
        end
        else if (frame_pos < IDLE_POS)
        begin
            if (frame_pos == LENGTH_POS)
            begin
                length_byte = b;
            end
            else if (frame_pos == TYPE_POS)
            begin
                crc_acc = crc_shift(crc_acc, b);
            end
            else if (frame_pos <= LAST_PAYLOAD)
            begin
                payload_bytes[frame_pos - FIRST_PAYLOAD] = b;
                crc_acc = crc_shift(crc_acc, b);
            end
            else if (length_byte != EXPECTED_LEN)
            begin
                queue_result(STATUS_BAD_LENGTH, 4'd0, '0, 1'b1);
            end
            else if (crc_acc != b)
            begin
                queue_result(STATUS_BAD_CRC, 4'd0, '0, 1'b1);
            end
            else
            begin
                for (i = 0; i < PAYLOAD_BYTES; i++)
                begin
                    flat[i*8 +: 8] = payload_bytes[i];
                end
                for (i = 0; i < NUM_CH; i++)
                begin
                    queue_result(STATUS_OK, 4'(i), flat[i*CH_W +: CH_W], i == NUM_CH - 1);
                end
            end
            frame_pos = frame_pos + 5'd1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        chan_result_t want;
        if (!rst_n)
        begin
            frame_pos   = IDLE_POS;
            length_byte = '0;
            crc_acc     = '0;
            due_results.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata, s_tuser[0]);
            end
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    if (errs < 30)
                    begin
                        $display("%0t unexpected result: expected none, actual tdata %h last %0d",
                                 $time, m_tdata, m_tlast);
                    end
                    errs++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (m_tdata[1:0] != want.status)
                    begin
                        flag("status", want.status, m_tdata[1:0]);
                    end
                    if (m_tdata[5:2] != want.index)
                    begin
                        flag("channel_index", want.index, m_tdata[5:2]);
                    end
                    if (m_tdata[16:6] != want.value)
                    begin
                        flag("channel_value", want.value, m_tdata[16:6]);
                    end
                    if (m_tdata[23:17] != '0)
                    begin
                        flag("tdata padding", 0, m_tdata[23:17]);
                    end
                    if (m_tlast != want.last)
                    begin
                        flag("last", want.last, m_tlast);
                    end
                end
            end
            mismatches  <= errs;
            outstanding <= due_results.size();
        end
    end

endmodule

`default_nettype wire

@@ bench/rc_channel_frame_decoder_top_tb.sv @@
`default_nettype none

module rc_channel_frame_decoder_top_tb;

    import rcfd_pkg::*;

    // Cycles with no transfer on either side before the run is declared hung
    localparam int STALL_LIMIT = 1000;
    // Quiet cycles after the last result to catch stray extra results
    localparam int SETTLE      = 40;
    localparam int FRAME_BYTES = 26;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    wire logic   s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    wire logic   m_tvalid;
    logic        m_tready = 1'b0;
    wire logic [23:0] m_tdata;
    wire logic   m_tlast;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;

    // Bytes sent so far; decides when to stop
    int stim_bytes  = 0;

    // Burst state per side: a run of items either with no gaps or with random gaps
    bit src_calm = 1'b0;
    int src_run  = 0;
    bit snk_calm = 1'b0;
    int snk_run  = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    rc_channel_frame_decoder_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    rc_channel_frame_decoder_chk u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Watchdog: end the run when neither side has moved a transfer for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Draw the wait before the next item; switch between calm and gappy stretches
    task automatic draw_gap(inout bit calm, inout int run, output int gap);
        if (run == 0)
        begin
            run  = $urandom_range(8, 40);
            calm = ($urandom_range(0, 2) == 0);
        end
        run--;
        gap = calm ? 0 : $urandom_range(0, 5);
    endtask

    // CRC-8 over type and payload, byte-wise, for building well-formed frames
    function automatic logic [7:0] frame_crc(input logic [7:0] ftype,
                                             input logic [PAYLOAD_W-1:0] body);
        logic [7:0] c;
        int         i;
        int         k;
        c = '0;
        for (i = 0; i <= PAYLOAD_BYTES; i++)
        begin
            c = c ^ ((i == 0) ? ftype : body[(i-1)*8 +: 8]);
            for (k = 0; k < 8; k++)
            begin
                c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Mix flat, saturated and random payloads so channels hit 0 and 2047
    function automatic logic [PAYLOAD_W-1:0] draw_payload();
        logic [PAYLOAD_W-1:0] body;
        int                   mode;
        int                   i;
        mode = $urandom_range(0, 5);
        for (i = 0; i < PAYLOAD_BYTES; i++)
        begin
            case (mode)
                0:       body[i*8 +: 8] = 8'h00;
                1:       body[i*8 +: 8] = 8'hFF;
                2:       body[i*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: body[i*8 +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return body;
    endfunction

    // Present one byte and hold it until the block takes the transfer
    task automatic send_byte(input logic [7:0] b, input bit start);
        int gap;
        draw_gap(src_calm, src_run, gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= b;
        s_tuser[0] <= start;
        do @(posedge clk); while (!s_tready);
        stim_bytes++;
    endtask

    // Send the first 'cut' bytes of a frame; a short cut leaves it for a restart
    task automatic send_frame(input logic [7:0] len, input logic [7:0] ftype,
                              input logic [PAYLOAD_W-1:0] body, input bit crc_ok,
                              input int cut);
        logic [7:0] seq [FRAME_BYTES];
        logic [7:0] fcs;
        int         i;
        fcs = frame_crc(ftype, body);
        if (!crc_ok)
        begin
            fcs = fcs ^ 8'($urandom_range(1, 255));
        end
        seq[0] = 8'($urandom_range(0, 255));
        seq[1] = len;
        seq[2] = ftype;
        for (i = 0; i < PAYLOAD_BYTES; i++)
        begin
            seq[3 + i] = body[i*8 +: 8];
        end
        seq[FRAME_BYTES - 1] = fcs;
        for (i = 0; i < cut; i++)
        begin
            send_byte(seq[i], i == 0);
        end
    endtask

    // Result side: stall at random, with stretches of steady acceptance
    initial
    begin
        int gap;
        forever
        begin
            draw_gap(snk_calm, snk_run, gap);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int         seqs;
        int         kind;
        int         n;
        logic [7:0] len;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Stray bytes while idle must be dropped
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Good frame with every payload bit set: all channels at full scale
        send_frame(EXPECTED_LEN, 8'hFF, '1, 1'b1, FRAME_BYTES);
        // Bytes after a finished frame are dropped until the next start
        send_byte(8'hA5, 1'b0);

        // Open with one each of kinds 0 to 4, then random kinds, half of them good frames
        seqs = 0;
        while (seqs < 5 || stim_bytes < 110)
        begin
            if (seqs < 5)
            begin
                kind = seqs;
            end
            else
            begin
                n    = $urandom_range(0, 19);
                kind = (n < 10) ? 0 : (n < 13) ? 1 : (n < 15) ? 2 :
                       (n < 16) ? 3 : (n < 18) ? 4 : 5;
            end
            len = 8'($urandom_range(0, 255));
            if (len == EXPECTED_LEN)
            begin
                len = 8'($urandom_range(0, 1) ? 0 : 255);
            end
            case (kind)
                // good frame
                0: send_frame(EXPECTED_LEN, 8'($urandom_range(0, 255)), draw_payload(),
                              1'b1, FRAME_BYTES);
                // CRC mismatch
                1: send_frame(EXPECTED_LEN, 8'($urandom_range(0, 255)), draw_payload(),
                              1'b0, FRAME_BYTES);
                // wrong length byte, CRC good
                2: send_frame(len, 8'($urandom_range(0, 255)), draw_payload(),
                              1'b1, FRAME_BYTES);
                // wrong length and bad CRC: length error wins
                3: send_frame(len, 8'($urandom_range(0, 255)), draw_payload(),
                              1'b0, FRAME_BYTES);
                // partial frame, abandoned by the next start
                4: send_frame(EXPECTED_LEN, 8'($urandom_range(0, 255)), draw_payload(),
                              1'b1, $urandom_range(1, FRAME_BYTES - 1));
                // noise without a start flag
                default:
                begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            endcase
            seqs++;
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every owed result, then watch for extras
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
